>>> src/ohp_pkg.sv
// Shared types, codes and helpers for the object handle pool.
package ohp_pkg;

  localparam int HANDLE_W = 32;
  localparam int TYPE_W   = 32;
  localparam int TRY_W    = 17;
  localparam int TOTAL_W  = 7;

  localparam logic [TRY_W-1:0] SEARCH_LIMIT = 17'd100000;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WAIT,
    ST_RESP
  } state_t;

  // Kind of beat traveling down the slot chain.
  typedef enum logic [2:0] {
    K_NONE,
    K_PROBE,
    K_FREE,
    K_QUERY,
    K_CLAIM,
    K_MARK
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [HANDLE_W-1:0] handle;
    logic [TYPE_W-1:0]   obj_type;
    logic                hit;
  } cell_beat_t;

  typedef struct packed {
    logic [1:0]          operation;
    logic [TYPE_W-1:0]   obj_type;
    logic [HANDLE_W-1:0] handle_in;
  } in_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle_out;
    logic                status;
    logic                is_live;
    logic [TOTAL_W-1:0]  live_total;
    logic [TOTAL_W-1:0]  peak_total;
  } out_item_t;

  // Advance a handle, skipping zero on wrap.
  function automatic logic [HANDLE_W-1:0] bump_handle(input logic [HANDLE_W-1:0] h);
    logic [HANDLE_W-1:0] n;
    n = h + {{(HANDLE_W-1){1'b0}}, 1'b1};
    return (n == '0) ? {{(HANDLE_W-1){1'b0}}, 1'b1} : n;
  endfunction

endpackage

>>> src/ohp_chan_if.sv
// Valid/ready channel interface carrying one payload item per beat.
interface ohp_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/object_handle_pool.sv
// Top level of the object handle pool: controller plus a row of slot cells.
//
// Usage: in_ch takes one request beat (allocate, free or query); out_ch
// returns exactly one result beat per request, in order. One request is
// worked at a time; in_ch.ready is high only while the block is idle.
// Every slot is a cell in a row; a request travels down the row one cell
// per cycle. Free and query make one pass of the row; allocate sends
// probes that skip handles a live slot already holds, then a claim (or
// a marker if the search gives up); allocate on a full pool and an unused
// opcode answer without a pass. Collision probes for successive candidate
// handles enter the row in successive cycles.
// The result holds in an output register until out_ch.ready; the block
// stalls (no new request) while the receiver stalls.
// Reset (synchronous, rst_n low) empties every slot, sets the next
// handle to one and clears the live and peak counts; no clearing pass.
module object_handle_pool
  import ohp_pkg::*;
#(
  parameter int POOL_SLOTS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  ohp_chan_if.sink   in_ch,
  ohp_chan_if.source out_ch
);

  localparam int CNT_W = ($clog2(POOL_SLOTS + 1) > TOTAL_W) ?
                         $clog2(POOL_SLOTS + 1) : TOTAL_W;

  state_t              state_r, state_nxt;
  logic [HANDLE_W-1:0] next_handle_r, next_handle_nxt;
  logic [HANDLE_W-1:0] cand_r, cand_nxt;
  logic [TRY_W-1:0]    tries_r, tries_nxt;
  logic [TYPE_W-1:0]   type_r, type_nxt;
  kind_t               wait_kind_r, wait_kind_nxt;
  logic [CNT_W-1:0]    live_r, live_nxt;
  logic [CNT_W-1:0]    peak_r, peak_nxt;
  logic [HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  logic                res_status_r, res_status_nxt;
  logic                res_live_r, res_live_nxt;

  cell_beat_t          chain [POOL_SLOTS+1];
  cell_beat_t          head_beat;
  cell_beat_t          tail;
  in_item_t            req;
  logic                in_fire;
  logic                pool_full;
  logic                probe_done;

  assign req        = in_ch.data;
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign pool_full  = (live_r == CNT_W'(POOL_SLOTS));
  assign tail       = chain[POOL_SLOTS];
  // a probe ends the search when it found a free handle or used the last try
  assign probe_done = (tail.kind == K_PROBE) && (!tail.hit || tries_r == SEARCH_LIMIT);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_RESP);

  assign out_ch.data.handle_out = res_handle_r;
  assign out_ch.data.status     = res_status_r;
  assign out_ch.data.is_live    = res_live_r;
  assign out_ch.data.live_total = live_r[TOTAL_W-1:0];
  assign out_ch.data.peak_total = peak_r[TOTAL_W-1:0];

  // Feed the head of the row from the controller.
  assign chain[0] = head_beat;

  // Row of slot cells; each hands its beat to the next cell every cycle.
  for (genvar i = 0; i < POOL_SLOTS; i++) begin : g_cell
    ohp_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .beat_i (chain[i]),
      .beat_o (chain[i+1])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (req.operation)
            OP_ALLOC:          state_nxt = pool_full ? ST_RESP : ST_SEARCH;
            OP_FREE, OP_QUERY: state_nxt = ST_WAIT;
            default:           state_nxt = ST_RESP;
          endcase
        end
      end
      ST_SEARCH: if (probe_done) state_nxt = ST_WAIT;
      ST_WAIT:   if (tail.kind == wait_kind_r) state_nxt = ST_RESP;
      ST_RESP:   if (out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, beat injection and results.
  always_comb begin
    next_handle_nxt = next_handle_r;
    cand_nxt        = cand_r;
    tries_nxt       = tries_r;
    type_nxt        = type_r;
    wait_kind_nxt   = wait_kind_r;
    live_nxt        = live_r;
    peak_nxt        = peak_r;
    res_handle_nxt  = res_handle_r;
    res_status_nxt  = res_status_r;
    res_live_nxt    = res_live_r;
    head_beat       = '{kind: K_NONE, handle: '0, obj_type: '0, hit: 1'b0};

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          type_nxt       = req.obj_type;
          cand_nxt       = next_handle_r;
          tries_nxt      = '0;
          res_handle_nxt = '0;
          res_status_nxt = 1'b1;
          res_live_nxt   = 1'b0;
          case (req.operation)
            OP_FREE: begin
              head_beat.kind   = K_FREE;
              head_beat.handle = req.handle_in;
              wait_kind_nxt    = K_FREE;
            end
            OP_QUERY: begin
              head_beat.kind   = K_QUERY;
              head_beat.handle = req.handle_in;
              wait_kind_nxt    = K_QUERY;
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (tail.kind == K_PROBE && !tail.hit) begin
          // free handle found: send the claim down the row
          head_beat       = '{kind: K_CLAIM, handle: tail.handle, obj_type: type_r, hit: 1'b0};
          next_handle_nxt = bump_handle(tail.handle);
          res_handle_nxt  = tail.handle;
          wait_kind_nxt   = K_CLAIM;
        end else if (probe_done) begin
          // give up; the marker flushes probes still in the row
          head_beat.kind  = K_MARK;
          next_handle_nxt = bump_handle(tail.handle);
          res_handle_nxt  = '0;
          wait_kind_nxt   = K_MARK;
        end else begin
          head_beat.kind   = K_PROBE;
          head_beat.handle = cand_r;
          cand_nxt         = bump_handle(cand_r);
          if (tail.kind == K_PROBE) tries_nxt = tries_r + 1'b1;
        end
      end
      ST_WAIT: begin
        if (tail.kind == wait_kind_r) begin
          case (wait_kind_r)
            K_CLAIM: begin
              res_status_nxt = 1'b0;
              live_nxt       = live_r + 1'b1;
              if (live_nxt > peak_r) peak_nxt = live_nxt;
            end
            K_FREE: begin
              res_status_nxt = !tail.hit;
              if (tail.hit && live_r != '0) live_nxt = live_r - 1'b1;
            end
            K_QUERY: begin
              res_status_nxt = 1'b0;
              res_live_nxt   = tail.hit;
            end
            default: res_status_nxt = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      next_handle_r <= {{(HANDLE_W-1){1'b0}}, 1'b1};
      live_r        <= '0;
      peak_r        <= '0;
    end else begin
      state_r       <= state_nxt;
      next_handle_r <= next_handle_nxt;
      live_r        <= live_nxt;
      peak_r        <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r       <= cand_nxt;
    tries_r      <= tries_nxt;
    type_r       <= type_nxt;
    wait_kind_r  <= wait_kind_nxt;
    res_handle_r <= res_handle_nxt;
    res_status_r <= res_status_nxt;
    res_live_r   <= res_live_nxt;
  end

endmodule

>>> src/ohp_cell.sv
// One pool slot: holds a handle and type, matches and updates passing beats.
module ohp_cell
  import ohp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_beat_t beat_i,
  output cell_beat_t beat_o
);

  logic                live_r, live_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic [TYPE_W-1:0]   type_r, type_nxt;
  cell_beat_t          beat_r, beat_nxt;
  logic                match;

  assign match  = live_r && (handle_r == beat_i.handle);
  assign beat_o = beat_r;

  always_comb begin
    live_nxt   = live_r;
    handle_nxt = handle_r;
    type_nxt   = type_r;
    beat_nxt   = beat_i;
    case (beat_i.kind)
      K_PROBE, K_QUERY: begin
        if (match) beat_nxt.hit = 1'b1;
      end
      K_FREE: begin
        if (!beat_i.hit && match) begin
          live_nxt     = 1'b0;
          handle_nxt   = '0;
          type_nxt     = '0;
          beat_nxt.hit = 1'b1;
        end
      end
      K_CLAIM: begin
        // first free slot down the row takes the new handle
        if (!beat_i.hit && !live_r) begin
          live_nxt     = 1'b1;
          handle_nxt   = beat_i.handle;
          type_nxt     = beat_i.obj_type;
          beat_nxt.hit = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= 1'b0;
      beat_r.kind <= K_NONE;
    end else begin
      live_r <= live_nxt;
      beat_r <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    handle_r <= handle_nxt;
    type_r   <= type_nxt;
  end

endmodule
